/* hdl/ccc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants for the connected component counter: widths,
// controller states and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // field widths
  localparam int END_W   = 10;
  localparam int LABEL_W = 11;
  localparam int COUNT_W = 11;
  localparam int NEED_W  = 10;

  // node count after reset
  localparam logic [COUNT_W-1:0] NODES_RESET = 11'd1024;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_CAPT,
    ST_DECIDE,
    ST_NEW_B,
    ST_SWEEP,
    ST_REPORT
  } state_t;

  // label store read address source
  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_SWEEP
  } rd_sel_t;

  // label store write operation
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_A_NEW,
    WR_B_NEW,
    WR_A_LB,
    WR_B_LA,
    WR_SWEEP
  } wr_op_t;

  // controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    latch_in;
    rd_sel_t rd_sel;
    logic    cap_la;
    logic    cap_lb;
    wr_op_t  wr_op;
    logic    cnt_clear;
    logic    cnt_inc;
    logic    new_group;
    logic    add_one;
    logic    merge_groups;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_skip;
    logic la_zero;
    logic lb_zero;
    logic labels_equal;
    logic clear_last;
    logic sweep_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* hdl/connected_component_counter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow: a self-loop or out-of-range edge goes from idle straight to the result;
// a join passes the label lookups of both ends and the decision, a new group also
// writes b's label, and a merge adds a relabel sweep over all D = min(MAX_NODES, 1024)
// entries through the store's one read port. One edge at a time: none is taken until
// the last result is loaded. Reset (synchronous): counts clear, node count goes to
// 1024, then a clearing pass zeroes the label store while no edge is accepted.
// ----------------------------------------------------------------------------
// connected_component_counter
// Quick-find connected component counter: labels nodes edge by edge and
// reports the number of components and the edges still needed to join them.
// ----------------------------------------------------------------------------
module connected_component_counter
  import ccc_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [COUNT_W-1:0]  cfg_data,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [END_W-1:0]    end_a,
  input  wire logic [END_W-1:0]    end_b,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [COUNT_W-1:0]  components,
  output      logic [NEED_W-1:0]   edges_needed,
  output      logic                bad_edge
);

  cmd_t    cmd;
  status_t status;

  // requests are taken only when the controller is idle
  assign in_stall = !cmd.in_ready;

  ccc_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .status  (status),
    .cmd     (cmd)
  );

  ccc_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .end_a       (end_a),
    .end_b       (end_b),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .components  (components),
    .edges_needed(edges_needed),
    .bad_edge    (bad_edge)
  );

endmodule
`default_nettype wire

/* hdl/ccc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output      logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/ccc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_datapath
// Label store, edge registers, group and node counters, sweep counter,
// node count register and the result register.
// ----------------------------------------------------------------------------
module ccc_datapath
  import ccc_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output      status_t             status,
  input  wire logic [END_W-1:0]    end_a,
  input  wire logic [END_W-1:0]    end_b,
  input  wire logic                cfg_write,
  input  wire logic [COUNT_W-1:0]  cfg_data,
  input  wire logic                out_stall,
  output      logic                out_valid,
  output      logic [COUNT_W-1:0]  components,
  output      logic [NEED_W-1:0]   edges_needed,
  output      logic                bad_edge
);

  // nodes beyond the input range are never addressed
  localparam int DEPTH = (MAX_NODES < (1 << END_W)) ? MAX_NODES : (1 << END_W);
  localparam int AW    = $clog2(DEPTH);

  logic [COUNT_W-1:0] nodes_in_use;
  logic [COUNT_W-1:0] eff_nodes;
  logic [END_W-1:0]   a_reg;
  logic [END_W-1:0]   b_reg;
  logic               bad_reg;
  logic               in_bad;
  logic [LABEL_W-1:0] la_reg;
  logic [LABEL_W-1:0] lb_reg;
  logic [LABEL_W-1:0] new_label;
  logic [AW:0]        cnt;
  logic [COUNT_W-1:0] group_count;
  logic [COUNT_W-1:0] assigned_count;
  logic [COUNT_W-1:0] lone;
  logic [COUNT_W-1:0] comps;
  logic [NEED_W-1:0]  need;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [LABEL_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [LABEL_W-1:0] ram_rdata;

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use <= NODES_RESET;
    end else if (cfg_write) begin
      nodes_in_use <= cfg_data;
    end
  end

  // effective node count, clamped to one and to the node limit
  always_comb begin
    if (nodes_in_use == '0) begin
      eff_nodes = COUNT_W'(1);
    end else if (32'(nodes_in_use) > 32'(MAX_NODES)) begin
      eff_nodes = COUNT_W'(MAX_NODES);
    end else begin
      eff_nodes = nodes_in_use;
    end
  end

  // out-of-range endpoint check on the incoming request
  assign in_bad = ({1'b0, end_a} >= eff_nodes) || ({1'b0, end_b} >= eff_nodes);

  // edge registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_reg   <= end_a;
      b_reg   <= end_b;
      bad_reg <= in_bad;
    end
  end

  // captured labels of both ends
  always_ff @(posedge clk) begin
    if (cmd.cap_la) begin
      la_reg <= ram_rdata;
    end
    if (cmd.cap_lb) begin
      lb_reg <= ram_rdata;
    end
  end

  // shared clear and sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + (AW+1)'(1);
    end
  end

  // group and labeled node counters
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count    <= '0;
      assigned_count <= '0;
    end else begin
      if (cmd.new_group) begin
        group_count    <= group_count + COUNT_W'(1);
        assigned_count <= assigned_count + COUNT_W'(2);
      end else if (cmd.add_one) begin
        assigned_count <= assigned_count + COUNT_W'(1);
      end else if (cmd.merge_groups && group_count != '0) begin
        group_count <= group_count - COUNT_W'(1);
      end
    end
  end

  // a new group is named after node a
  assign new_label = {1'b0, a_reg} + LABEL_W'(1);

  // label store read address
  always_comb begin
    case (cmd.rd_sel)
      RD_A:     ram_raddr = AW'(a_reg);
      RD_B:     ram_raddr = AW'(b_reg);
      RD_SWEEP: ram_raddr = cnt[AW-1:0];
      default:  ram_raddr = cnt[AW-1:0];
    endcase
  end

  // label store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = '0;
    case (cmd.wr_op)
      WR_NONE: begin
        ram_we = 1'b0;
      end
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = '0;
      end
      WR_A_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(a_reg);
        ram_wdata = new_label;
      end
      WR_B_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(b_reg);
        ram_wdata = new_label;
      end
      WR_A_LB: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(a_reg);
        ram_wdata = lb_reg;
      end
      WR_B_LA: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(b_reg);
        ram_wdata = la_reg;
      end
      WR_SWEEP: begin
        // registered read data belongs to the previous address
        ram_we    = (cnt != '0) && (ram_rdata == lb_reg);
        ram_waddr = AW'(cnt - (AW+1)'(1));
        ram_wdata = la_reg;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ccc_ram #(
    .WIDTH(LABEL_W),
    .DEPTH(DEPTH)
  ) u_label_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // component count: groups plus lone nodes
  always_comb begin
    lone  = (eff_nodes > assigned_count) ? (eff_nodes - assigned_count) : '0;
    comps = group_count + lone;
    need  = (comps != '0) ? NEED_W'(comps - COUNT_W'(1)) : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      components   <= comps;
      edges_needed <= need;
      bad_edge     <= bad_reg;
    end
  end

  // status back to the controller
  assign status.in_skip      = in_bad || (end_a == end_b);
  assign status.la_zero      = (la_reg == '0);
  assign status.lb_zero      = (lb_reg == '0);
  assign status.labels_equal = (la_reg == lb_reg);
  assign status.clear_last   = (cnt == (AW+1)'(DEPTH - 1));
  assign status.sweep_done   = (cnt == (AW+1)'(DEPTH));
  assign status.out_free     = !out_valid || !out_stall;

  // every group holds at least two labeled nodes
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, group_count} << 1) <= {1'b0, assigned_count})
    else $error("group count exceeds half the labeled nodes");

  // no more labeled nodes than the store holds
  assert property (@(posedge clk) disable iff (rst)
    32'(assigned_count) <= 32'(DEPTH))
    else $error("labeled node count exceeds store depth");

  // a reported result always counts at least one component
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (components != '0))
    else $error("result reports zero components");

endmodule
`default_nettype wire

/* hdl/ccc_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_controller
// State machine that runs the clearing pass, the label lookups, the merge
// decision, the relabel sweep and the result hand-off.
// ----------------------------------------------------------------------------
module ccc_controller
  import ccc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output      cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.rd_sel       = RD_A;
    cmd.wr_op        = WR_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.wr_op   = WR_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (status.clear_last) begin
          cmd.cnt_clear = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = status.in_skip ? ST_REPORT : ST_LOOK_A;
        end
      end
      ST_LOOK_A: begin
        cmd.rd_sel = RD_A;
        state_next = ST_LOOK_B;
      end
      ST_LOOK_B: begin
        cmd.rd_sel = RD_B;
        cmd.cap_la = 1'b1;
        state_next = ST_CAPT;
      end
      ST_CAPT: begin
        cmd.cap_lb = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.la_zero && status.lb_zero) begin
          // both alone: start a new group
          cmd.wr_op     = WR_A_NEW;
          cmd.new_group = 1'b1;
          state_next    = ST_NEW_B;
        end else if (status.la_zero) begin
          cmd.wr_op   = WR_A_LB;
          cmd.add_one = 1'b1;
          state_next  = ST_REPORT;
        end else if (status.lb_zero) begin
          cmd.wr_op   = WR_B_LA;
          cmd.add_one = 1'b1;
          state_next  = ST_REPORT;
        end else if (!status.labels_equal) begin
          // two groups: relabel b's group over the whole store
          cmd.cnt_clear    = 1'b1;
          cmd.merge_groups = 1'b1;
          state_next       = ST_SWEEP;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_NEW_B: begin
        cmd.wr_op  = WR_B_NEW;
        state_next = ST_REPORT;
      end
      ST_SWEEP: begin
        cmd.rd_sel  = RD_SWEEP;
        cmd.wr_op   = WR_SWEEP;
        cmd.cnt_inc = 1'b1;
        if (status.sweep_done) begin
          cmd.cnt_clear = 1'b1;
          state_next    = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result register loaded while full and stalled");

  // the sweep only ends after a full pass of the counter
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && !status.sweep_done) |=> (state == ST_SWEEP))
    else $error("relabel sweep left early");

  // requests are latched only from idle with a valid request
  assert property (@(posedge clk) disable iff (rst)
    cmd.latch_in |-> (state == ST_IDLE && in_valid))
    else $error("request latched outside idle");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the connected component counter. Edge requests are
// driven with random gaps and result stalls. A label tracker keeps its own
// quick-find image of the graph. From it the tracker works out the expected
// component count, edges needed and bad-edge flag for every accepted request.
// ----------------------------------------------------------------------------
module tb;
  import ccc_pkg::*;

  localparam int NODE_LIMIT    = 1024;
  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 70;

  typedef struct packed {
    logic [COUNT_W-1:0] comps;
    logic [NEED_W-1:0]  need;
    logic               bad;
  } tally_t;

  // label tracker: own copy of the label store, counts and node register
  class component_tracker;
    logic [LABEL_W-1:0] label_of [NODE_LIMIT];
    int                 groups;
    int                 labeled;
    logic [COUNT_W-1:0] node_reg;
    tally_t             expected_tallies[$];
    int                 mismatches;

    function new();
      foreach (label_of[i]) label_of[i] = '0;
      groups     = 0;
      labeled    = 0;
      node_reg   = NODES_RESET;
      mismatches = 0;
    endfunction

    function int eff_nodes();
      if (node_reg == 0) return 1;
      if (int'(node_reg) > NODE_LIMIT) return NODE_LIMIT;
      return int'(node_reg);
    endfunction

    function int pending();
      return expected_tallies.size();
    endfunction

    // merge one accepted edge and queue the tally it should report
    function void apply_edge(input logic [END_W-1:0] a, input logic [END_W-1:0] b);
      int                 n;
      int                 comps;
      logic [LABEL_W-1:0] la;
      logic [LABEL_W-1:0] lb;
      tally_t             t;
      n = eff_nodes();
      t.bad = (int'(a) >= n) || (int'(b) >= n);
      if (!t.bad && a != b) begin
        la = label_of[a];
        lb = label_of[b];
        if (la == 0 && lb == 0) begin
          label_of[a] = LABEL_W'(int'(a) + 1);
          label_of[b] = LABEL_W'(int'(a) + 1);
          groups++;
          labeled += 2;
        end else if (la == 0) begin
          label_of[a] = lb;
          labeled++;
        end else if (lb == 0) begin
          label_of[b] = la;
          labeled++;
        end else if (la != lb) begin
          // relabel all of b's group with a's label
          foreach (label_of[i]) if (label_of[i] == lb) label_of[i] = la;
          if (groups > 0) groups--;
        end
      end
      comps  = groups + ((n > labeled) ? n - labeled : 0);
      t.comps = COUNT_W'(comps);
      t.need  = NEED_W'((comps > 0) ? comps - 1 : 0);
      expected_tallies = {expected_tallies, t};
    endfunction

    function void flag_mismatch(input string msg);
      if (mismatches < 10) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_report(input logic [COUNT_W-1:0] comps,
                               input logic [NEED_W-1:0] need, input logic bad);
      tally_t t;
      if (expected_tallies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result comps=%0d need=%0d bad=%0b",
                                comps, need, bad));
        return;
      end
      t = expected_tallies.pop_front();
      if (comps !== t.comps || need !== t.need || bad !== t.bad)
        flag_mismatch($sformatf("expected comps=%0d need=%0d bad=%0b, got %0d %0d %0b",
                                t.comps, t.need, t.bad, comps, need, bad));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [COUNT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [END_W-1:0]   end_a;
  logic [END_W-1:0]   end_b;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] components;
  logic [NEED_W-1:0]  edges_needed;
  logic               bad_edge;
  bit                 quiet;

  component_tracker tracker = new();

  connected_component_counter #(
    .MAX_NODES(NODE_LIMIT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_a       (end_a),
    .end_b       (end_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .components  (components),
    .edges_needed(edges_needed),
    .bad_edge    (bad_edge)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop for a hung run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function bit idle_roll();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // result side stalls at random
  always @(negedge clk) begin
    out_stall <= idle_roll();
  end

  // accepted results go to the tracker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_report(components, edges_needed, bad_edge);
  end

  // send one edge request, called and returning at a falling edge
  task automatic send_edge(input logic [END_W-1:0] a, input logic [END_W-1:0] b);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    end_a    <= a;
    end_b    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_edge(a, b);
    @(negedge clk);
  endtask

  // wait for all results, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_nodes(input logic [COUNT_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.node_reg = v;
  endtask

  // random phase: mostly in-range edges, some self-loops and out-of-range ends
  task automatic run_random(input logic [COUNT_W-1:0] nodes, input int count);
    int               n;
    int               roll;
    logic [END_W-1:0] a;
    logic [END_W-1:0] b;
    logic [END_W-1:0] swap;
    write_nodes(nodes);
    n = tracker.eff_nodes();
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        a = END_W'($urandom_range(n - 1, 0));
        b = a;
      end else if (roll < 20 && n < NODE_LIMIT) begin
        a = END_W'($urandom_range(NODE_LIMIT - 1, n));
        b = END_W'($urandom_range(NODE_LIMIT - 1, 0));
        if ($urandom_range(1) == 1) begin
          swap = a;
          a    = b;
          b    = swap;
        end
      end else begin
        a = END_W'($urandom_range(n - 1, 0));
        b = END_W'($urandom_range(n - 1, 0));
      end
      send_edge(a, b);
    end
  endtask

  // main sequence
  initial begin
    int phase_nodes[8];
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    end_a     = '0;
    end_b     = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
    phase_nodes = '{16, 1024, 2, 64, 0, 1024, 8, 300};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed, reset node count: new group, joins, self-loop, merge, same group
    send_edge(10'd0, 10'd1);
    send_edge(10'd1, 10'd2);
    send_edge(10'd3, 10'd2);
    send_edge(10'd5, 10'd5);
    send_edge(10'd1023, 10'd1022);
    send_edge(10'd1022, 10'd1023);
    send_edge(10'd0, 10'd1023);
    send_edge(10'd2, 10'd1022);
    send_edge(10'd512, 10'd511);

    // node count zero acts as one, count lowered below labeled nodes
    write_nodes(11'd0);
    send_edge(10'd0, 10'd0);
    send_edge(10'd0, 10'd1);
    send_edge(10'd1, 10'd0);
    send_edge(10'd1023, 10'd1023);

    // register above the node limit
    write_nodes(11'd2047);
    send_edge(10'd4, 10'd6);
    send_edge(10'd7, 10'd6);
    write_nodes(11'd1025);
    send_edge(10'd1023, 10'd5);

    // boundary of a small node count
    write_nodes(11'd3);
    send_edge(10'd2, 10'd3);
    send_edge(10'd3, 10'd2);
    send_edge(10'd2, 10'd2);
    write_nodes(11'd1);
    send_edge(10'd0, 10'd0);
    send_edge(10'd0, 10'd1);

    // random phases over several node counts
    foreach (phase_nodes[p]) begin
      quiet = (p == 1);
      if (phase_nodes[p] == 0)
        run_random(COUNT_W'($urandom_range(2047, 0)), PHASE_ITEMS);
      else
        run_random(COUNT_W'(phase_nodes[p]), PHASE_ITEMS);
    end
    quiet = 1'b0;

    settle();
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hdl/ccc_pkg.sv
hdl/ccc_ram.sv
hdl/ccc_datapath.sv
hdl/ccc_controller.sv
hdl/connected_component_counter.sv
tb/sv/tb.sv
